// File: hdl/jns_pkg.sv
// Shared codes and types for the JSON number scanner.
// Holds scan phases, command, event and status codes, and character constants.
// No dependencies.
`default_nettype none

package jns_pkg;

  localparam logic [3:0] PH_START      = 4'd0;
  localparam logic [3:0] PH_AFTER_SIGN = 4'd1;
  localparam logic [3:0] PH_AFTER_ZERO = 4'd2;
  localparam logic [3:0] PH_INT        = 4'd3;
  localparam logic [3:0] PH_FRAC       = 4'd4;
  localparam logic [3:0] PH_EXP_START  = 4'd5;
  localparam logic [3:0] PH_EXP_SIGN   = 4'd6;
  localparam logic [3:0] PH_EXP_DIGITS = 4'd7;
  localparam logic [3:0] PH_DONE       = 4'd8;
  localparam logic [3:0] PH_ERROR      = 4'd9;

  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_END     = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_MAN_MINUS = 3'd1;
  localparam logic [2:0] EV_MAN_POINT = 3'd2;
  localparam logic [2:0] EV_MAN_DIGIT = 3'd3;
  localparam logic [2:0] EV_EXP_MINUS = 3'd4;
  localparam logic [2:0] EV_EXP_DIGIT = 3'd5;

  localparam logic [1:0] ST_RUNNING  = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_ERROR    = 2'd2;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;

  typedef struct packed {
    logic [3:0] phase;
    logic       mantissa_seen;
    logic       exponent_seen;
  } jns_state_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [3:0] digit_value;
    logic       consumed;
    logic [1:0] status;
    logic       mantissa_empty;
    logic       exponent_empty;
  } jns_result_t;

endpackage

`default_nettype wire

// File: hdl/json_number_scanner.sv
// Top level of the JSON number scanner: scan state and output register.
// Uses jns_pkg and jns_step.
//
// Takes one request per cycle while in_stall is low (a text byte, end of input
// or restart) and gives one result per request, in the cycle after acceptance,
// from a single result register. Throughput is one request per clock while
// in_stall is low; the only loop is the scan state register fed by the jns_step
// decode. in_stall rises only while a result is held and out_stall is high.
`default_nettype none

module json_number_scanner (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] cmd,
  input  wire logic [7:0] text_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      event_res,
  output logic [3:0]      digit_value,
  output logic            consumed,
  output logic [1:0]      status,
  output logic            mantissa_empty,
  output logic            exponent_empty
);

  jns_pkg::jns_state_t  state;
  jns_pkg::jns_state_t  state_next;
  jns_pkg::jns_result_t step_result;
  jns_pkg::jns_result_t result;
  logic                 accept;

  jns_step u_step (
    .state      (state),
    .cmd        (cmd),
    .text_byte  (text_byte),
    .state_next (state_next),
    .result     (step_result)
  );

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= jns_pkg::PH_START;
      state.mantissa_seen <= 1'b0;
      state.exponent_seen <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      if (accept) begin
        state <= state_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= step_result;
    end
  end

  assign event_res      = result.event_res;
  assign digit_value    = result.digit_value;
  assign consumed       = result.consumed;
  assign status         = result.status;
  assign mantissa_empty = result.mantissa_empty;
  assign exponent_empty = result.exponent_empty;

endmodule

`default_nettype wire

// File: hdl/jns_step.sv
// Next-state and result decode for one request of the JSON number scanner.
// Pure combinational logic; uses jns_pkg.
`default_nettype none

module jns_step (
  input  wire jns_pkg::jns_state_t  state,
  input  wire logic [1:0]           cmd,
  input  wire logic [7:0]           text_byte,
  output jns_pkg::jns_state_t       state_next,
  output jns_pkg::jns_result_t      result
);

  typedef struct packed {
    logic [2:0] event_res;
    logic [3:0] digit_value;
    logic       consumed;
    logic [3:0] phase_next;
  } jns_move_t;

  function automatic logic is_numeral(input logic [7:0] c);
    return (c >= jns_pkg::CH_ZERO) && (c <= jns_pkg::CH_NINE);
  endfunction

  function automatic logic [3:0] digit_of(input logic [7:0] c);
    logic [7:0] diff;
    diff = c - jns_pkg::CH_ZERO;
    return diff[3:0];
  endfunction

  function automatic jns_move_t mantissa_move(input logic in_frac, input logic [7:0] c);
    jns_move_t m;
    m = '0;
    priority if (is_numeral(c)) begin
      m.event_res   = jns_pkg::EV_MAN_DIGIT;
      m.digit_value = digit_of(c);
      m.consumed    = 1'b1;
      m.phase_next  = in_frac ? jns_pkg::PH_FRAC : jns_pkg::PH_INT;
    end else if (c == jns_pkg::CH_LOW_E || c == jns_pkg::CH_UP_E) begin
      m.consumed   = 1'b1;
      m.phase_next = jns_pkg::PH_EXP_START;
    end else if (!in_frac && c == jns_pkg::CH_POINT) begin
      m.event_res  = jns_pkg::EV_MAN_POINT;
      m.consumed   = 1'b1;
      m.phase_next = jns_pkg::PH_FRAC;
    end else begin
      m.phase_next = jns_pkg::PH_DONE;
    end
    return m;
  endfunction

  function automatic jns_move_t after_sign_move(input logic [7:0] c);
    jns_move_t m;
    m = '0;
    if (c == jns_pkg::CH_ZERO) begin
      m.consumed   = 1'b1;
      m.phase_next = jns_pkg::PH_AFTER_ZERO;
    end else begin
      m = mantissa_move(1'b0, c);
    end
    return m;
  endfunction

  function automatic jns_move_t exponent_move(input logic [7:0] c);
    jns_move_t m;
    m = '0;
    if (is_numeral(c)) begin
      m.event_res   = jns_pkg::EV_EXP_DIGIT;
      m.digit_value = digit_of(c);
      m.consumed    = 1'b1;
      m.phase_next  = jns_pkg::PH_EXP_DIGITS;
    end else begin
      m.phase_next = jns_pkg::PH_DONE;
    end
    return m;
  endfunction

  function automatic jns_move_t exp_start_move(input logic [7:0] c);
    jns_move_t m;
    m = '0;
    priority if (c == jns_pkg::CH_MINUS) begin
      m.event_res  = jns_pkg::EV_EXP_MINUS;
      m.consumed   = 1'b1;
      m.phase_next = jns_pkg::PH_EXP_SIGN;
    end else if (c == jns_pkg::CH_PLUS) begin
      m.consumed   = 1'b1;
      m.phase_next = jns_pkg::PH_EXP_SIGN;
    end else begin
      m = exponent_move(c);
    end
    return m;
  endfunction

  function automatic logic [1:0] status_of(input logic [3:0] ph);
    logic [1:0] st;
    st = jns_pkg::ST_RUNNING;
    if (ph == jns_pkg::PH_DONE) st = jns_pkg::ST_COMPLETE;
    if (ph == jns_pkg::PH_ERROR) st = jns_pkg::ST_ERROR;
    return st;
  endfunction

  jns_move_t move;
  logic      finished;

  assign finished = (state.phase >= jns_pkg::PH_DONE);

  always_comb begin
    move = '0;
    move.phase_next = state.phase;
    unique case (state.phase)
      jns_pkg::PH_START: begin
        priority if (text_byte == jns_pkg::CH_PLUS) begin
          move.consumed   = 1'b1;
          move.phase_next = jns_pkg::PH_AFTER_SIGN;
        end else if (text_byte == jns_pkg::CH_MINUS) begin
          move.event_res  = jns_pkg::EV_MAN_MINUS;
          move.consumed   = 1'b1;
          move.phase_next = jns_pkg::PH_AFTER_SIGN;
        end else begin
          move = after_sign_move(text_byte);
        end
      end
      jns_pkg::PH_AFTER_SIGN: move = after_sign_move(text_byte);
      jns_pkg::PH_AFTER_ZERO: begin
        if (text_byte == jns_pkg::CH_POINT) begin
          move.event_res  = jns_pkg::EV_MAN_POINT;
          move.consumed   = 1'b1;
          move.phase_next = jns_pkg::PH_FRAC;
        end else begin
          move.phase_next = jns_pkg::PH_ERROR;
        end
      end
      jns_pkg::PH_INT:        move = mantissa_move(1'b0, text_byte);
      jns_pkg::PH_FRAC:       move = mantissa_move(1'b1, text_byte);
      jns_pkg::PH_EXP_START:  move = exp_start_move(text_byte);
      jns_pkg::PH_EXP_SIGN,
      jns_pkg::PH_EXP_DIGITS: move = exponent_move(text_byte);
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    result     = '0;
    priority if (cmd == jns_pkg::CMD_RESTART) begin
      state_next = '0;
      state_next.phase = jns_pkg::PH_START;
    end else if (cmd == jns_pkg::CMD_UNUSED || finished) begin
      result.status = status_of(state.phase);
    end else if (cmd == jns_pkg::CMD_END) begin
      if (state.phase == jns_pkg::PH_START || state.phase == jns_pkg::PH_AFTER_SIGN ||
          state.phase == jns_pkg::PH_EXP_START || state.phase == jns_pkg::PH_EXP_SIGN) begin
        state_next.phase = jns_pkg::PH_ERROR;
        result.status    = jns_pkg::ST_ERROR;
      end else begin
        state_next.phase      = jns_pkg::PH_DONE;
        result.status         = jns_pkg::ST_COMPLETE;
        result.mantissa_empty = !state.mantissa_seen;
        result.exponent_empty = !state.exponent_seen;
      end
    end else begin
      state_next.phase = move.phase_next;
      if (move.event_res >= jns_pkg::EV_MAN_MINUS && move.event_res <= jns_pkg::EV_MAN_DIGIT)
        state_next.mantissa_seen = 1'b1;
      if (move.event_res >= jns_pkg::EV_EXP_MINUS)
        state_next.exponent_seen = 1'b1;
      result.event_res   = move.event_res;
      result.digit_value = move.digit_value;
      result.consumed    = move.consumed;
      result.status      = status_of(move.phase_next);
    end
  end

endmodule

`default_nettype wire
